// ----- hw/rtl/tccw_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Text console character writer: shared definitions
// Types, command codes, character codes and default sizes used by the
// front end, the back end and the queues of the console writer.
// ----------------------------------------------------------------------------
package tccw_pkg;

  // Default screen geometry
  localparam int DEF_COLUMNS = 80;
  localparam int DEF_ROWS    = 25;

  // Entries in each decoupling queue (power of two, two or more)
  localparam int QUEUE_DEPTH = 2;

  // Widths of the cell position fields carried in a queued command
  localparam int ROW_FLD_W = 6;
  localparam int COL_FLD_W = 7;

  // Input command codes
  localparam logic [1:0] CMD_PUT   = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  // Character codes
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DEL   = 8'h7F;

  localparam int TAB_STEP = 8;

  localparam logic [7:0]  RESET_ATTR  = 8'h0F;
  localparam logic [15:0] RESET_BLANK = {RESET_ATTR, CH_SPACE};

  // Classified operation, decided by the front end
  typedef enum logic [2:0] {
    OP_NOP,
    OP_PRINT,
    OP_NL,
    OP_CR,
    OP_TAB,
    OP_BS,
    OP_READ,
    OP_CLEAR
  } op_t;

  typedef struct packed {
    op_t                  op;
    logic [7:0]           ch;
    logic [ROW_FLD_W-1:0] row;
    logic [COL_FLD_W-1:0] col;
  } cmd_t;

  typedef struct packed {
    logic [6:0]  cursor_col;
    logic [4:0]  cursor_row;
    logic [10:0] cursor_offset;
    logic [15:0] cell_value;
    logic        did_scroll;
  } res_t;

  // Back end sequencer states
  typedef enum logic [2:0] {
    S_FILL,
    S_IDLE,
    S_EXEC,
    S_SCROLL,
    S_DONE
  } state_t;

endpackage
`default_nettype wire

// ----- hw/rtl/tccw_queue.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Console writer queue
// Small first-in first-out buffer of DEPTH entries (a power of two) with
// push/full on the write side and pop/empty on the read side.
// ----------------------------------------------------------------------------
module tccw_queue import tccw_pkg::*; #(
  parameter int WIDTH = 1,
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  output logic                  full,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      rdata,
  output logic                  empty
);

  localparam int PW    = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] store_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r;
  logic [PW-1:0]    rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             do_push;
  logic             do_pop;

  assign full    = (cnt_r == CNT_W'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;
  assign rdata   = store_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + PW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + PW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      store_r[wr_ptr_r] <= wdata;
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/tccw_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Console writer front end
// Accepts input items, sorts each into one operation (printable, control
// character, cell read, clear or nothing) and queues it for the back end.
// ----------------------------------------------------------------------------
module tccw_front import tccw_pkg::*; #(
  parameter int COLUMNS = DEF_COLUMNS,
  parameter int ROWS    = DEF_ROWS
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_push,
  output logic            in_full,
  input  wire logic [1:0] in_command,
  input  wire logic [7:0] in_char_code,
  input  wire logic [4:0] in_cell_row,
  input  wire logic [6:0] in_cell_col,
  input  wire logic       init_busy,
  output logic            cmd_valid,
  input  wire logic       cmd_pop,
  output cmd_t            cmd
);

  cmd_t                  cmd_in;
  logic                  q_full;
  logic                  q_empty;
  logic [$bits(cmd_t)-1:0] q_rdata;

  always_comb begin
    cmd_in.op  = OP_NOP;
    cmd_in.ch  = in_char_code;
    cmd_in.row = ROW_FLD_W'(in_cell_row);
    cmd_in.col = in_cell_col;
    unique case (in_command)
      CMD_PUT: begin
        if (in_char_code == CH_NL) begin
          cmd_in.op = OP_NL;
        end else if (in_char_code == CH_CR) begin
          cmd_in.op = OP_CR;
        end else if (in_char_code == CH_TAB) begin
          cmd_in.op = OP_TAB;
        end else if (in_char_code == CH_BS) begin
          cmd_in.op = OP_BS;
        end else if (in_char_code >= CH_SPACE && in_char_code <= CH_DEL) begin
          cmd_in.op = OP_PRINT;
        end
      end
      CMD_READ: begin
        // out-of-range reads report a zero cell
        if (int'(in_cell_row) < ROWS && int'(in_cell_col) < COLUMNS) begin
          cmd_in.op = OP_READ;
        end
      end
      CMD_CLEAR: begin
        cmd_in.op = OP_CLEAR;
      end
      default: begin
        cmd_in.op = OP_NOP;
      end
    endcase
  end

  // hold off items while the screen store is being blanked after reset
  assign in_full = q_full | init_busy;

  tccw_queue #(
    .WIDTH ($bits(cmd_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_cmd_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (in_push & ~init_busy),
    .wdata (cmd_in),
    .full  (q_full),
    .pop   (cmd_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  assign cmd_valid = ~q_empty;
  assign cmd       = cmd_t'(q_rdata);

endmodule
`default_nettype wire

// ----- hw/rtl/tccw_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Console writer back end
// Sequencer that owns the screen store and the cursor. The store is kept as
// a ring of rows: scrolling moves the top-row base and blanks one row.
// ----------------------------------------------------------------------------
module tccw_back import tccw_pkg::*; #(
  parameter int COLUMNS = DEF_COLUMNS,
  parameter int ROWS    = DEF_ROWS
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic [7:0] attr,
  input  wire logic       cmd_valid,
  output logic            cmd_pop,
  input  wire cmd_t       cmd,
  input  wire logic       res_full,
  output logic            res_push,
  output res_t            res,
  output logic            init_busy
);

  localparam int CELL_COUNT = ROWS * COLUMNS;
  localparam int AW         = $clog2(CELL_COUNT);
  localparam int CW         = $clog2(COLUMNS);
  localparam int RW         = $clog2(ROWS);

  state_t        state_r;
  state_t        state_nxt;
  logic [CW-1:0] col_r;
  logic [RW-1:0] row_r;
  logic [RW-1:0] base_r;
  logic [AW-1:0] swp_r;
  logic [15:0]   fill_val_r;
  logic          fill_clear_r;
  cmd_t          cmd_r;
  logic          scroll_r;
  logic          cell_sel_r;
  logic [AW-1:0] row_addr_r;
  logic [15:0]   rd_data_r;
  logic [15:0]   mem [CELL_COUNT];

  // execute-step signals
  logic [CW:0]   nc;
  logic [RW:0]   nr;
  logic [RW-1:0] a_row;
  logic [CW-1:0] a_col;
  logic          ex_we;
  logic          ex_re;
  logic [15:0]   ex_wd;
  logic          ex_scroll;
  logic [RW:0]   pr_sum;
  logic [RW-1:0] pr_row;
  logic [AW-1:0] ex_addr;

  logic          mem_we;
  logic          mem_re;
  logic [AW-1:0] mem_addr;
  logic [15:0]   mem_wd;
  logic [AW-1:0] ofs;

  // new cursor and store access for the command in hand
  always_comb begin
    nc    = {1'b0, col_r};
    nr    = {1'b0, row_r};
    a_row = row_r;
    a_col = col_r;
    ex_we = 1'b0;
    ex_re = 1'b0;
    ex_wd = {attr, cmd_r.ch};
    unique case (cmd_r.op)
      OP_PRINT: begin
        ex_we = 1'b1;
        nc    = nc + (CW+1)'(1);
      end
      OP_NL: begin
        nc = '0;
        nr = nr + (RW+1)'(1);
      end
      OP_CR: begin
        nc = '0;
      end
      OP_TAB: begin
        nc = (nc + (CW+1)'(TAB_STEP)) & ~(CW+1)'(TAB_STEP - 1);
      end
      OP_BS: begin
        if (col_r != '0) begin
          nc    = nc - (CW+1)'(1);
          a_col = col_r - CW'(1);
          ex_we = 1'b1;
          ex_wd = {attr, CH_SPACE};
        end
      end
      OP_READ: begin
        a_row = RW'(cmd_r.row);
        a_col = CW'(cmd_r.col);
        ex_re = 1'b1;
      end
      OP_CLEAR, OP_NOP: begin
      end
    endcase
    // eager wrap
    if (nc >= (CW+1)'(COLUMNS)) begin
      nc = '0;
      nr = nr + (RW+1)'(1);
    end
    ex_scroll = (nr == (RW+1)'(ROWS));
  end

  // logical row to physical row through the ring base
  always_comb begin
    pr_sum = {1'b0, a_row} + {1'b0, base_r};
    if (pr_sum >= (RW+1)'(ROWS)) begin
      pr_sum = pr_sum - (RW+1)'(ROWS);
    end
    pr_row  = pr_sum[RW-1:0];
    ex_addr = AW'(pr_row) * AW'(COLUMNS) + AW'(a_col);
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_FILL: begin
        if (swp_r == AW'(CELL_COUNT - 1)) begin
          state_nxt = fill_clear_r ? S_DONE : S_IDLE;
        end
      end
      S_IDLE: begin
        if (cmd_valid) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (cmd_r.op == OP_CLEAR) begin
          state_nxt = S_FILL;
        end else if (ex_scroll) begin
          state_nxt = S_SCROLL;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_SCROLL: begin
        if (swp_r == AW'(COLUMNS - 1)) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!res_full) begin
          state_nxt = S_IDLE;
        end
      end
    endcase
  end

  always_comb begin
    mem_we   = 1'b0;
    mem_re   = 1'b0;
    mem_addr = ex_addr;
    mem_wd   = ex_wd;
    cmd_pop  = 1'b0;
    res_push = 1'b0;
    unique case (state_r)
      S_FILL: begin
        mem_we   = 1'b1;
        mem_addr = swp_r;
        mem_wd   = fill_val_r;
      end
      S_IDLE: begin
        cmd_pop = cmd_valid;
      end
      S_EXEC: begin
        mem_we = ex_we;
        mem_re = ex_re;
      end
      S_SCROLL: begin
        mem_we   = 1'b1;
        mem_addr = row_addr_r + swp_r;
        mem_wd   = {attr, CH_SPACE};
      end
      S_DONE: begin
        res_push = ~res_full;
      end
    endcase
  end

  assign init_busy = (state_r == S_FILL) & ~fill_clear_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_FILL;
      swp_r        <= '0;
      fill_val_r   <= RESET_BLANK;
      fill_clear_r <= 1'b0;
      col_r        <= '0;
      row_r        <= '0;
      base_r       <= '0;
    end else begin
      state_r <= state_nxt;
      unique case (state_r)
        S_FILL, S_SCROLL: begin
          swp_r <= swp_r + AW'(1);
        end
        S_EXEC: begin
          swp_r <= '0;
          if (cmd_r.op == OP_CLEAR) begin
            col_r        <= '0;
            row_r        <= '0;
            base_r       <= '0;
            fill_val_r   <= {attr, CH_SPACE};
            fill_clear_r <= 1'b1;
          end else begin
            col_r <= nc[CW-1:0];
            if (ex_scroll) begin
              // old top row becomes the blank bottom row
              row_r  <= RW'(ROWS - 1);
              base_r <= (base_r == RW'(ROWS - 1)) ? '0 : base_r + RW'(1);
            end else begin
              row_r <= nr[RW-1:0];
            end
          end
        end
        S_IDLE, S_DONE: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && cmd_valid) begin
      cmd_r <= cmd;
    end
    if (state_r == S_EXEC) begin
      scroll_r   <= ex_scroll & (cmd_r.op != OP_CLEAR);
      cell_sel_r <= ex_re;
      row_addr_r <= AW'(base_r) * AW'(COLUMNS);
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wd;
    end
    if (mem_re) begin
      rd_data_r <= mem[mem_addr];
    end
  end

  assign ofs = AW'(row_r) * AW'(COLUMNS) + AW'(col_r);

  always_comb begin
    res.cursor_col    = 7'(col_r);
    res.cursor_row    = 5'(row_r);
    res.cursor_offset = 11'(ofs);
    res.cell_value    = cell_sel_r ? rd_data_r : 16'h0000;
    res.did_scroll    = scroll_r;
  end

endmodule
`default_nettype wire

// ----- hw/rtl/text_console_char_writer.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Text console character writer
// Text-mode console engine: ROWS x COLUMNS store of attribute/character
// cells with a cursor; put character, read cell and clear screen commands.
// ----------------------------------------------------------------------------
// Timing: after reset the screen store is blanked one cell a cycle, and full
// stays high until every cell is blank. Items are queued by the front end
// and carried out one at a time by the back-end sequencer, which owns the
// single-port-write screen memory. An item that does not scroll passes
// through fetch, execute and hand-over of the result; an item that scrolls
// also blanks the freed row before the hand-over, as rows are kept in a ring
// and never copied; clear screen blanks every cell before its hand-over.
// Results wait in an output queue, so a slow reader stalls the sequencer only
// once that queue is full.
module text_console_char_writer import tccw_pkg::*; #(
  parameter int COLUMNS = DEF_COLUMNS,
  parameter int ROWS    = DEF_ROWS
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_push,
  output logic             in_full,
  input  wire logic [1:0]  in_command,
  input  wire logic [7:0]  in_char_code,
  input  wire logic [4:0]  in_cell_row,
  input  wire logic [6:0]  in_cell_col,
  output logic             out_empty,
  input  wire logic        out_pop,
  output logic [6:0]       out_cursor_col,
  output logic [4:0]       out_cursor_row,
  output logic [10:0]      out_cursor_offset,
  output logic [15:0]      out_cell_value,
  output logic             out_did_scroll,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [7:0]  cfg_data
);

  logic [7:0]            attr_r;
  logic                  init_busy;
  logic                  cmd_valid;
  logic                  cmd_pop;
  cmd_t                  cmd;
  logic                  res_full;
  logic                  res_push;
  res_t                  res;
  res_t                  res_out;
  logic [$bits(res_t)-1:0] res_rdata;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attr_r <= RESET_ATTR;
    end else if (cfg_valid) begin
      attr_r <= cfg_data;
    end
  end

  tccw_front #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_push      (in_push),
    .in_full      (in_full),
    .in_command   (in_command),
    .in_char_code (in_char_code),
    .in_cell_row  (in_cell_row),
    .in_cell_col  (in_cell_col),
    .init_busy    (init_busy),
    .cmd_valid    (cmd_valid),
    .cmd_pop      (cmd_pop),
    .cmd          (cmd)
  );

  tccw_back #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .attr      (attr_r),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop),
    .cmd       (cmd),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res),
    .init_busy (init_busy)
  );

  tccw_queue #(
    .WIDTH ($bits(res_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_res_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res),
    .full  (res_full),
    .pop   (out_pop),
    .rdata (res_rdata),
    .empty (out_empty)
  );

  assign res_out           = res_t'(res_rdata);
  assign out_cursor_col    = res_out.cursor_col;
  assign out_cursor_row    = res_out.cursor_row;
  assign out_cursor_offset = res_out.cursor_offset;
  assign out_cell_value    = res_out.cell_value;
  assign out_did_scroll    = res_out.did_scroll;

endmodule
`default_nettype wire
